// ===== design/gbfd_pkg.sv =====
package gbfd_pkg;

  // Frame layout.
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned CRC_BYTES    = 4;

  localparam logic [7:0] SYNC1 = 8'hAA;
  localparam logic [7:0] SYNC2 = 8'h44;
  localparam logic [7:0] SYNC3 = 8'hB5;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // Header byte offsets of the little-endian id and length fields.
  localparam logic [16:0] OFS_ID_LO  = 17'd4;
  localparam logic [16:0] OFS_ID_HI  = 17'd5;
  localparam logic [16:0] OFS_LEN_LO = 17'd6;
  localparam logic [16:0] OFS_LEN_HI = 17'd7;
  localparam logic [16:0] OFS_HDR_LAST = 17'(HEADER_BYTES - 1);
  localparam logic [15:0] CRC_COUNT = 16'(CRC_BYTES);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_SYNC3  = 3'd2,
    PH_HEADER = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_HUNT     = 2'd0,
    ST_IN_FRAME = 2'd1,
    ST_CRC_GOOD = 2'd2,
    ST_CRC_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [16:0] frame_offset;
    logic [15:0] message_id;
    logic [15:0] payload_length;
    logic        header_done;
    logic [7:0]  byte_echo;
  } result_t;

  // Reflected CRC-32 update over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/gbfd_parser.sv =====
module gbfd_parser
  import gbfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] byte_in,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [16:0] ofs_r, ofs_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] len_r, len_nxt;

  // Parser state, advanced once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      crc_r   <= '0;
      ofs_r   <= '0;
      left_r  <= '0;
      id_r    <= '0;
      len_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      ofs_r   <= ofs_nxt;
      left_r  <= left_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
    end
  end

  // Next state and the result for the current byte.
  always_comb begin
    logic        hunt;
    logic        hd;
    status_t     st;
    logic [31:0] crc_upd;
    logic [16:0] ofs_inc;
    hunt      = 1'b0;
    hd        = 1'b0;
    st        = ST_IN_FRAME;
    crc_upd   = crc_byte(crc_r, byte_in);
    ofs_inc   = ofs_r + 17'd1;
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    ofs_nxt   = ofs_r;
    left_nxt  = left_r;
    id_nxt    = id_r;
    len_nxt   = len_r;

    unique case (phase_r)
      PH_SYNC2: begin
        if (byte_in != SYNC2) begin
          hunt = 1'b1;
        end else begin
          ofs_nxt   = ofs_inc;
          crc_nxt   = crc_upd;
          phase_nxt = PH_SYNC3;
        end
      end
      PH_SYNC3: begin
        if (byte_in != SYNC3) begin
          hunt = 1'b1;
        end else begin
          ofs_nxt   = ofs_inc;
          crc_nxt   = crc_upd;
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        ofs_nxt = ofs_inc;
        crc_nxt = crc_upd;
        if (ofs_inc == OFS_ID_LO)  id_nxt  = {id_r[15:8], byte_in};
        if (ofs_inc == OFS_ID_HI)  id_nxt  = {byte_in, id_r[7:0]};
        if (ofs_inc == OFS_LEN_LO) len_nxt = {len_r[15:8], byte_in};
        if (ofs_inc == OFS_LEN_HI) len_nxt = {byte_in, len_r[7:0]};
        if (ofs_inc >= OFS_HDR_LAST) begin
          hd = 1'b1;
          // An empty payload skips straight to the CRC bytes.
          if (len_nxt == 16'd0) begin
            left_nxt  = CRC_COUNT;
            phase_nxt = PH_CRC;
          end else begin
            left_nxt  = len_nxt;
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        ofs_nxt = ofs_inc;
        crc_nxt = crc_upd;
        hd      = 1'b1;
        if (left_r <= 16'd1) begin
          left_nxt  = CRC_COUNT;
          phase_nxt = PH_CRC;
        end else begin
          left_nxt = left_r - 16'd1;
        end
      end
      PH_CRC: begin
        ofs_nxt = ofs_inc;
        crc_nxt = crc_upd;
        hd      = 1'b1;
        if (left_r <= 16'd1) begin
          left_nxt  = '0;
          st        = (crc_upd == 32'd0) ? ST_CRC_GOOD : ST_CRC_BAD;
          phase_nxt = PH_HUNT;
        end else begin
          left_nxt = left_r - 16'd1;
        end
      end
      default: begin
        hunt = 1'b1;
      end
    endcase

    // A byte outside a frame, or a broken sync, is checked as a new start.
    if (hunt) begin
      if (byte_in == SYNC1) begin
        crc_nxt   = crc_byte(32'd0, byte_in);
        ofs_nxt   = '0;
        left_nxt  = '0;
        id_nxt    = '0;
        len_nxt   = '0;
        phase_nxt = PH_SYNC2;
        st        = ST_IN_FRAME;
      end else begin
        phase_nxt = PH_HUNT;
        ofs_nxt   = '0;
        st        = ST_HUNT;
      end
    end

    res.status         = st;
    res.frame_offset   = (st == ST_HUNT) ? 17'd0 : ofs_nxt;
    res.message_id     = hd ? id_nxt : 16'd0;
    res.payload_length = hd ? len_nxt : 16'd0;
    res.header_done    = hd;
    res.byte_echo      = byte_in;
  end

endmodule

// ===== design/gnss_binary_frame_deframer.sv =====
// Byte-stream deframer for binary GNSS frames: it hunts for the sync bytes AA 44 B5,
// latches the message id and payload length from the header, counts the payload and
// checks the trailing reflected CRC-32, giving one status request per input byte.
// It takes one byte per clock cycle when the output is not stalled, and each byte goes
// through the input register and then the result register; the rate is set by the
// byte-wide CRC update, done combinationally between those two registers.
module gnss_binary_frame_deframer
  import gbfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [16:0] out_frame_offset,
  output logic [15:0] out_message_id,
  output logic [15:0] out_payload_length,
  output logic        out_header_done,
  output logic [7:0]  out_byte_echo
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       out_v_r;
  result_t    res_r;
  result_t    res;
  logic       advance;

  // The result register moves when it is empty or being taken.
  assign advance  = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte_in;
    end
  end

  gbfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_v_r && advance),
    .byte_in (in_byte_r),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = res_r.status;
  assign out_frame_offset   = res_r.frame_offset;
  assign out_message_id     = res_r.message_id;
  assign out_payload_length = res_r.payload_length;
  assign out_header_done    = res_r.header_done;
  assign out_byte_echo      = res_r.byte_echo;

endmodule

// ===== verif/tb_gnss_binary_frame_deframer.sv =====
module tb_gnss_binary_frame_deframer;
  import gbfd_pkg::*;

  localparam int unsigned RANDOM_FRAME_BYTES = 1600;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned SYNC_CASE_COUNT = 15;

  typedef enum {FR_GOOD, FR_CORRUPT, FR_TRUNCATED} frame_kind_t;

  // One byte of the sync-hunting table with the result it must give.
  typedef struct packed {
    logic [7:0]  data;
    status_t     status;
    logic [16:0] offset;
  } sync_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [16:0] out_frame_offset;
  logic [15:0] out_message_id;
  logic [15:0] out_payload_length;
  logic        out_header_done;
  logic [7:0]  out_byte_echo;

  // Parser state mirrored by the testbench.
  phase_t      ph_q;
  logic [31:0] crc_acc;
  logic [16:0] byte_pos;
  logic [15:0] count_left;
  logic [15:0] id_latch;
  logic [15:0] len_latch;

  result_t     deframe_q[$];
  int unsigned mismatch_count = 0;
  int unsigned frame_bytes = 0;
  bit          burst = 1'b0;

  // Sync hunting: stray sync bytes, wrong second and third bytes, and a wrong
  // byte that is itself a first sync byte.
  sync_case_t sync_cases [SYNC_CASE_COUNT] = '{
    '{8'h00, ST_HUNT,     17'd0},
    '{8'hFF, ST_HUNT,     17'd0},
    '{SYNC2, ST_HUNT,     17'd0},
    '{SYNC3, ST_HUNT,     17'd0},
    '{SYNC1, ST_IN_FRAME, 17'd0},
    '{8'h00, ST_HUNT,     17'd0},
    '{SYNC1, ST_IN_FRAME, 17'd0},
    '{SYNC1, ST_IN_FRAME, 17'd0},
    '{SYNC2, ST_IN_FRAME, 17'd1},
    '{8'h00, ST_HUNT,     17'd0},
    '{SYNC1, ST_IN_FRAME, 17'd0},
    '{SYNC2, ST_IN_FRAME, 17'd1},
    '{SYNC1, ST_IN_FRAME, 17'd0},
    '{SYNC2, ST_IN_FRAME, 17'd1},
    '{SYNC2, ST_HUNT,     17'd0}
  };

  gnss_binary_frame_deframer dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Reflected CRC-32, one data bit per step, LSB first.
  function automatic logic [31:0] crc32_reflect(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] c;
    logic        fb;
    int          k;
    c = acc;
    for (k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Advances the mirrored parser by one byte and gives the result it causes.
  task automatic deframe_byte(input logic [7:0] data, output result_t res);
    bit      hunt;
    bit      hd;
    status_t st;
    hunt = 1'b0;
    hd = 1'b0;
    st = ST_IN_FRAME;
    case (ph_q)
      PH_SYNC2: begin
        if (data != SYNC2) begin
          hunt = 1'b1;
        end else begin
          byte_pos = byte_pos + 17'd1;
          crc_acc = crc32_reflect(crc_acc, data);
          ph_q = PH_SYNC3;
        end
      end
      PH_SYNC3: begin
        if (data != SYNC3) begin
          hunt = 1'b1;
        end else begin
          byte_pos = byte_pos + 17'd1;
          crc_acc = crc32_reflect(crc_acc, data);
          ph_q = PH_HEADER;
        end
      end
      PH_HEADER: begin
        byte_pos = byte_pos + 17'd1;
        crc_acc = crc32_reflect(crc_acc, data);
        if (byte_pos == OFS_ID_LO) id_latch[7:0] = data;
        if (byte_pos == OFS_ID_HI) id_latch[15:8] = data;
        if (byte_pos == OFS_LEN_LO) len_latch[7:0] = data;
        if (byte_pos == OFS_LEN_HI) len_latch[15:8] = data;
        if (byte_pos >= OFS_HDR_LAST) begin
          hd = 1'b1;
          // An empty payload skips straight to the CRC bytes.
          if (len_latch == 16'd0) begin
            count_left = CRC_COUNT;
            ph_q = PH_CRC;
          end else begin
            count_left = len_latch;
            ph_q = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        byte_pos = byte_pos + 17'd1;
        crc_acc = crc32_reflect(crc_acc, data);
        hd = 1'b1;
        if (count_left <= 16'd1) begin
          count_left = CRC_COUNT;
          ph_q = PH_CRC;
        end else begin
          count_left = count_left - 16'd1;
        end
      end
      PH_CRC: begin
        byte_pos = byte_pos + 17'd1;
        crc_acc = crc32_reflect(crc_acc, data);
        hd = 1'b1;
        if (count_left <= 16'd1) begin
          count_left = 16'd0;
          st = (crc_acc == 32'd0) ? ST_CRC_GOOD : ST_CRC_BAD;
          ph_q = PH_HUNT;
        end else begin
          count_left = count_left - 16'd1;
        end
      end
      default: begin
        hunt = 1'b1;
      end
    endcase

    // A byte outside a frame, or one that breaks the sync, is looked at as a first sync byte.
    if (hunt) begin
      if (data == SYNC1) begin
        crc_acc = crc32_reflect(32'd0, data);
        byte_pos = 17'd0;
        count_left = 16'd0;
        id_latch = 16'd0;
        len_latch = 16'd0;
        ph_q = PH_SYNC2;
        st = ST_IN_FRAME;
      end else begin
        ph_q = PH_HUNT;
        byte_pos = 17'd0;
        st = ST_HUNT;
      end
    end

    res.status = st;
    res.frame_offset = (st == ST_HUNT) ? 17'd0 : byte_pos;
    res.message_id = hd ? id_latch : 16'd0;
    res.payload_length = hd ? len_latch : 16'd0;
    res.header_done = hd;
    res.byte_echo = data;
  endtask

  // Offers one byte after a random gap and records its result once accepted.
  task automatic push_byte(input logic [7:0] data, input bit use_typed, input result_t typed_res);
    int unsigned gap;
    result_t     res;
    gap = burst ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= data;
    do @(posedge clk); while (in_stall);
    deframe_byte(data, res);
    deframe_q.push_back(use_typed ? typed_res : res);
  endtask

  // Builds a frame with a matching CRC, then damages or cuts it as asked.
  task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                            input frame_kind_t kind);
    logic [7:0]  bytes_q[$];
    logic [31:0] c;
    int          cut;
    int          pos;
    int          k;
    bytes_q.push_back(SYNC1);
    bytes_q.push_back(SYNC2);
    bytes_q.push_back(SYNC3);
    bytes_q.push_back(8'($urandom_range(0, 255)));
    bytes_q.push_back(id[7:0]);
    bytes_q.push_back(id[15:8]);
    bytes_q.push_back(len[7:0]);
    bytes_q.push_back(len[15:8]);
    while (bytes_q.size() < HEADER_BYTES + len) bytes_q.push_back(8'($urandom_range(0, 255)));
    c = 32'd0;
    for (k = 0; k < bytes_q.size(); k++) c = crc32_reflect(c, bytes_q[k]);
    for (k = 0; k < CRC_BYTES; k++) bytes_q.push_back(c[8*k +: 8]);

    // Damage stays clear of the length field so the framing stays bounded.
    cut = bytes_q.size();
    if (kind == FR_CORRUPT) begin
      pos = $urandom_range(8, bytes_q.size() - 1);
      bytes_q[pos] = bytes_q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end else if (kind == FR_TRUNCATED) begin
      cut = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2)
                                          : $urandom_range(8, bytes_q.size() - 1);
    end
    for (k = 0; k < cut; k++) begin
      push_byte(bytes_q[k], 1'b0, '0);
      frame_bytes++;
    end
  endtask

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: check each accepted request, then stall for a random while.
  initial begin
    int unsigned hold;
    result_t     want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (deframe_q.size() == 0) begin
          $error("result with no byte pending: byte_echo %0h", out_byte_echo);
          mismatch_count++;
        end else begin
          want = deframe_q.pop_front();
          check_field("status", 17'(want.status), 17'(out_status));
          check_field("frame_offset", want.frame_offset, out_frame_offset);
          check_field("message_id", 17'(want.message_id), 17'(out_message_id));
          check_field("payload_length", 17'(want.payload_length),
                      17'(out_payload_length));
          check_field("header_done", 17'(want.header_done), 17'(out_header_done));
          check_field("byte_echo", 17'(want.byte_echo), 17'(out_byte_echo));
        end
        hold = burst ? 0 : $urandom_range(0, 9);
      end
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any request moving on either side.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus.
  initial begin
    int          k;
    int          n;
    int unsigned pick;
    logic [15:0] len;
    logic [7:0]  b;
    result_t     want_row;
    ph_q = PH_HUNT;
    crc_acc = 32'd0;
    byte_pos = 17'd0;
    count_left = 16'd0;
    id_latch = 16'd0;
    len_latch = 16'd0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < SYNC_CASE_COUNT; k++) begin
      want_row = '0;
      want_row.status = sync_cases[k].status;
      want_row.frame_offset = sync_cases[k].offset;
      want_row.byte_echo = sync_cases[k].data;
      push_byte(sync_cases[k].data, 1'b1, want_row);
    end

    // Empty payloads with extreme ids, then the shortest non-empty payload.
    send_frame(16'h0000, 16'd0, FR_GOOD);
    send_frame(16'hFFFF, 16'd0, FR_CORRUPT);
    send_frame(16'h5AA5, 16'd1, FR_GOOD);

    // Mostly well-formed frames, with damaged frames, cut frames and noise.
    frame_bytes = 0;
    while (frame_bytes < RANDOM_FRAME_BYTES) begin
      burst = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(17, 300))
                                           : 16'($urandom_range(0, 16));
      if (pick < 70) begin
        send_frame(16'($urandom), len, FR_GOOD);
      end else if (pick < 80) begin
        send_frame(16'($urandom), len, FR_CORRUPT);
      end else if (pick < 88) begin
        send_frame(16'($urandom), len, FR_TRUNCATED);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: b = SYNC1;
            1: b = SYNC2;
            2: b = SYNC3;
            default: b = 8'($urandom_range(0, 255));
          endcase
          // Noise never completes a sync, so no random length gets latched.
          if (b == SYNC3 && ph_q == PH_SYNC3) b = 8'h00;
          push_byte(b, 1'b0, '0);
        end
      end
    end
    burst = 1'b0;

    // Finish any open frame, then send a long frame back to back.
    while (ph_q != PH_HUNT) push_byte(8'h00, 1'b0, '0);
    burst = 1'b1;
    send_frame(16'($urandom), 16'd200, FR_GOOD);
    burst = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (deframe_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gbfd_pkg.sv
design/gbfd_parser.sv
design/gnss_binary_frame_deframer.sv
verif/tb_gnss_binary_frame_deframer.sv
